[sv/iee_pkg.sv]
// Shared types, character codes and constants for the infix expression evaluator.
`timescale 1ns / 1ps
package iee_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OUT_WIDTH      = 32;
  localparam int CHAR_WIDTH     = 8;
  localparam int DIGIT_WIDTH    = 4;
  localparam int CMD_DEPTH      = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_DEPTH + 1);

  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_TIMES = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_PLUS  = 2'd0,
    OP_MINUS = 2'd1,
    OP_TIMES = 2'd2,
    OP_DIV   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_WAIT,
    ST_EMIT
  } back_state_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic                   dig_valid;
    logic [DIGIT_WIDTH-1:0] digit;
    logic                   apply;
    op_t                    op;
    logic                   last;
  } cmd_t;

endpackage

[sv/iee_in_if.sv]
// Character channel: valid/ready handshake carrying one expression character.
`timescale 1ns / 1ps
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

[sv/iee_out_if.sv]
// Result channel: valid/ready handshake carrying the expression value and error flag.
`timescale 1ns / 1ps
interface iee_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;
  logic              div_by_zero;

  modport source (output valid, output value, output div_by_zero, input ready);
  modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

[sv/infix_expression_evaluator.sv]
// Infix expression evaluator: one character a word in, one result word per expression out.
// A digit is taken up while the back end is idle; a + or - operator passes through APPLY,
// and a * or / also waits in WAIT for the shared one-bit-a-cycle multiply/divide unit (a /
// by zero skips it); the result word is registered in EMIT after the last operator,
// once the output is free. The back end pops a character only in IDLE; a 4-entry queue
// decouples intake. Synchronous active-high reset clears control and accumulator state.
`timescale 1ns / 1ps
module infix_expression_evaluator #(
  parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  iee_in_if.sink     chars,
  iee_out_if.source  results
);
  import iee_pkg::*;

  logic                  push;
  cmd_t                  push_cmd;
  logic                  full;
  logic                  pop;
  cmd_t                  head_cmd;
  logic                  empty;
  logic                  md_start;
  logic                  md_is_div;
  logic [DATA_WIDTH-1:0] md_a;
  logic [DATA_WIDTH-1:0] md_b;
  logic                  md_done;
  logic [DATA_WIDTH-1:0] md_result;

  iee_front u_front (
    .chars (chars),
    .full  (full),
    .push  (push),
    .cmd   (push_cmd)
  );

  iee_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (head_cmd),
    .empty (empty)
  );

  iee_muldiv #(.W(DATA_WIDTH)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .is_div (md_is_div),
    .opa    (md_a),
    .opb    (md_b),
    .done   (md_done),
    .result (md_result)
  );

  iee_back #(.W(DATA_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .md_start  (md_start),
    .md_is_div (md_is_div),
    .md_a      (md_a),
    .md_b      (md_b),
    .md_done   (md_done),
    .md_result (md_result),
    .results   (results)
  );

endmodule

[sv/iee_front.sv]
// Front end: accept characters, classify them and push commands into the queue.
`timescale 1ns / 1ps
module iee_front (
  iee_in_if.sink         chars,
  input  logic           full,
  output logic           push,
  output iee_pkg::cmd_t  cmd
);
  import iee_pkg::*;

  logic is_digit;
  logic is_space;
  op_t  char_op;

  assign is_digit = (chars.ch >= CH_ZERO) && (chars.ch <= CH_NINE);
  assign is_space = (chars.ch == CH_SPACE);

  always_comb begin
    unique case (chars.ch)
      CH_MINUS: char_op = OP_MINUS;
      CH_TIMES: char_op = OP_TIMES;
      CH_DIV:   char_op = OP_DIV;
      default:  char_op = OP_PLUS;
    endcase
  end

  assign chars.ready = !full;

  // drop plain spaces; everything else becomes a command
  assign push = chars.valid && !full && !(is_space && !chars.last);

  always_comb begin
    cmd.dig_valid = is_digit;
    cmd.digit     = DIGIT_WIDTH'(chars.ch - CH_ZERO);
    cmd.apply     = (!is_digit && !is_space) || chars.last;
    cmd.op        = char_op;
    cmd.last      = chars.last;
  end

endmodule

[sv/iee_cmd_fifo.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module iee_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  iee_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output iee_pkg::cmd_t dout,
  output logic          empty
);
  import iee_pkg::*;

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign full  = (count == CMD_CNT_W'(CMD_DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/iee_muldiv.sv]
// Shared iterative unit: shift-add multiply and restoring signed divide, one bit a cycle.
`timescale 1ns / 1ps
module iee_muldiv #(
  parameter int W = iee_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         is_div,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  output logic         done,
  output logic [W-1:0] result
);
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             div_mode;
  logic             neg;
  logic [W-1:0]     x;
  logic [W-1:0]     y;
  logic [W:0]       acc;

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W:0]   rem_sh;
  logic         q_bit;

  assign mag_a  = opa[W-1] ? (~opa + 1'b1) : opa;
  assign mag_b  = opb[W-1] ? (~opb + 1'b1) : opb;
  assign rem_sh = {acc[W-1:0], x[W-1]};
  assign q_bit  = (rem_sh >= {1'b0, y});

  assign result = div_mode ? (neg ? (~x + 1'b1) : x) : acc[W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      div_mode <= is_div;
      neg      <= opa[W-1] ^ opb[W-1];
      x        <= is_div ? mag_a : opa;
      y        <= is_div ? mag_b : opb;
      acc      <= '0;
    end else if (busy) begin
      if (div_mode) begin
        // x shifts the dividend out and the quotient in
        acc <= q_bit ? (rem_sh - {1'b0, y}) : rem_sh;
        x   <= {x[W-2:0], q_bit};
      end else begin
        if (y[0]) begin
          acc <= {1'b0, acc[W-1:0] + x};
        end
        x <= {x[W-2:0], 1'b0};
        y <= {1'b0, y[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/iee_back.sv]
// Back end: build numbers, apply pending operators and emit the result word.
`timescale 1ns / 1ps
module iee_back #(
  parameter int W = iee_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  iee_pkg::cmd_t cmd,
  output logic          pop,
  output logic          md_start,
  output logic          md_is_div,
  output logic [W-1:0]  md_a,
  output logic [W-1:0]  md_b,
  input  logic          md_done,
  input  logic [W-1:0]  md_result,
  iee_out_if.source     results
);
  import iee_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [W-1:0] partial_sum;
  logic [W-1:0] last_term;
  logic [W-1:0] current_number;
  op_t          pending_op;
  logic         error_seen;
  op_t          new_op;
  logic         last_r;
  logic         out_valid;

  logic need_md;
  logic out_free;
  logic close;
  logic emit;

  assign need_md  = (pending_op == OP_TIMES) ||
                    ((pending_op == OP_DIV) && (current_number != '0));
  assign out_free = !out_valid || results.ready;

  assign md_is_div = (pending_op == OP_DIV);
  assign md_a      = last_term;
  assign md_b      = current_number;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.apply) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (need_md) begin
          state_next = ST_WAIT;
        end else if (last_r) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          state_next = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    md_start = 1'b0;
    close    = 1'b0;
    emit     = 1'b0;
    unique case (state)
      ST_IDLE:  pop = cmd_valid;
      ST_APPLY: begin
        md_start = need_md;
        close    = !need_md;
      end
      ST_WAIT:  close = md_done;
      ST_EMIT:  emit = out_free;
      default:  pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum    <= '0;
      last_term      <= '0;
      current_number <= '0;
      pending_op     <= OP_PLUS;
      error_seen     <= 1'b0;
      new_op         <= OP_PLUS;
      last_r         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop && cmd.dig_valid) begin
        current_number <= (current_number << 3) + (current_number << 1) + W'(cmd.digit);
      end
      if (pop && cmd.apply) begin
        new_op <= cmd.op;
        last_r <= cmd.last;
      end

      if (state == ST_APPLY) begin
        case (pending_op)
          OP_PLUS: begin
            partial_sum <= partial_sum + last_term;
            last_term   <= current_number;
          end
          OP_MINUS: begin
            partial_sum <= partial_sum + last_term;
            last_term   <= ~current_number + 1'b1;
          end
          OP_DIV: begin
            // zero divisor: clear the open term and flag it
            if (current_number == '0) begin
              last_term  <= '0;
              error_seen <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if ((state == ST_WAIT) && md_done) begin
        last_term <= md_result;
      end

      if (close) begin
        current_number <= '0;
        pending_op     <= new_op;
      end

      if (emit) begin
        results.value       <= OUT_WIDTH'(partial_sum + last_term);
        results.div_by_zero <= error_seen;
        out_valid           <= 1'b1;
        partial_sum         <= '0;
        last_term           <= '0;
        current_number      <= '0;
        pending_op          <= OP_PLUS;
        error_seen          <= 1'b0;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid = out_valid;

endmodule
